### sv/sogi_pkg.sv
// shared types and constants of the sogi quadrature generator
// command and status records between controller and datapath, fixed field widths
// no dependencies
package sogi_pkg;

  localparam int CFG_DW = 32;
  localparam int CFG_IW = 2;

  localparam logic [CFG_IW-1:0] REG_GAIN_K        = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SAMPLE_PERIOD = 2'd1;
  localparam logic [CFG_IW-1:0] REG_DC_OFFSET     = 2'd2;

  localparam logic [15:0] GAIN_K_RESET = 16'd5793;
  localparam logic [31:0] PERIOD_RESET = 32'd429497;

  localparam int OMEGA_W    = 24;
  localparam int MW         = 32;
  localparam int PREG_W     = 2 * MW;
  localparam int X_W        = 27;
  localparam int KX_W       = 30;
  localparam int X2_W       = 29;
  localparam int KX2_W      = 32;
  localparam int D_W        = 32;
  localparam int NUM_W      = 32;
  localparam int COEF_FRAC  = 28;
  localparam int DVD_W      = NUM_W + COEF_FRAC;
  localparam int Q_W        = 31;
  localparam int STATE_FRAC = 16;

  localparam logic [X_W-1:0] WTS_MAX   = 27'h400_0000;
  localparam logic [D_W-1:0] FOUR_Q24  = 32'h0400_0000;

  typedef enum logic [2:0] {
    MS_OM_TS, MS_K_X, MS_X_X, MS_K_X2, MS_LO, MS_HI
  } mul_sel_t;

  typedef enum logic [1:0] {N_AB0, N_AA1, N_AA2, N_BB0} num_sel_t;

  typedef enum logic [2:0] {A_BP1, A_BP2, A_LP1, A_LP2, A_TMP} a_sel_t;

  typedef enum logic [2:0] {C_NAA1, C_NAA2, C_AB0, C_NAB0, C_BB0, C_BB1} c_sel_t;

  typedef struct packed {
    mul_sel_t mul;
    logic     load;
    logic     acc_u;
    logic     x_en;
    logic     kx_en;
    logic     x2_en;
    logic     kx2_en;
    logic     div_start;
    num_sel_t num;
    logic     coef_en;
    a_sel_t   asel;
    c_sel_t   csel;
    logic     prod_lo;
    logic     prod_add;
    logic     rnd;
    logic     acc_add;
    logic     tmp_en;
    logic     acc_clr;
    logic     outa_en;
    logic     outb_en;
    logic     shift_bp;
    logic     shift_lp;
    logic     res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } dp_sts_t;

endpackage

### sv/sogi_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// uses sogi_pkg for widths
module sogi_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sogi_pkg::DVD_W-1:0] dividend,
  input  logic [sogi_pkg::D_W-1:0]   divisor,
  output logic                      busy,
  output logic                      done,
  output logic [sogi_pkg::Q_W-1:0]   quotient
);
  import sogi_pkg::*;

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [D_W:0]     rem;
  logic [Q_W-1:0]   shreg;
  logic [D_W-1:0]   dsr;
  logic [CNT_W-1:0] cnt;
  logic [D_W+1:0]   trial;
  logic [D_W+1:0]   diff;
  logic             ge;

  assign trial    = {rem, shreg[Q_W-1]};
  assign diff     = trial - {2'b00, dsr};
  assign ge       = trial >= {2'b00, dsr};
  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(Q_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= (D_W+1)'(dividend[DVD_W-1:Q_W]);
      shreg <= dividend[Q_W-1:0];
      dsr   <= divisor;
    end else if (busy) begin
      rem   <= ge ? diff[D_W:0] : trial[D_W:0];
      shreg <= {shreg[Q_W-2:0], ge};
    end
  end

endmodule

### sv/sogi_dp.sv
// datapath: config registers, shared multiplier, coefficient divider, filter states
// uses sogi_pkg and sogi_div, driven by sogi_ctrl commands
module sogi_dp #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int STATE_WIDTH  = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [sogi_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [sogi_pkg::CFG_DW-1:0]       cfg_wdata,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample,
  input  logic [sogi_pkg::OMEGA_W-1:0]      in_omega,
  input  logic                              in_restart,
  input  sogi_pkg::dp_cmd_t                 cmd,
  output sogi_pkg::dp_sts_t                 sts,
  output logic signed [SAMPLE_WIDTH-1:0]    alpha,
  output logic signed [SAMPLE_WIDTH-1:0]    beta,
  output logic                              saturated
);
  import sogi_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int STW = STATE_WIDTH;
  localparam int UW  = SW + 1 + STATE_FRAC;
  localparam int EW  = (UW > STW) ? UW : STW;
  localparam int PW  = STW + MW;
  localparam int RW  = PW + 1 - COEF_FRAC;
  localparam int OW  = STW + 1 - STATE_FRAC;
  localparam int CW  = (OW > SW) ? OW : SW;

  localparam logic signed [STW-1:0] ST_MAX = {1'b0, {(STW-1){1'b1}}};
  localparam logic signed [STW-1:0] ST_MIN = {1'b1, {(STW-1){1'b0}}};
  localparam logic signed [SW-1:0]  SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]  SMP_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [STW:0]   OUT_HALF = (STW+1)'(2 ** (STATE_FRAC - 1));
  localparam logic [PW:0]           RND_HALF = (PW+1)'(2 ** (COEF_FRAC - 1));

  // config
  logic [15:0]          gain_k;
  logic [31:0]          sample_period;
  logic signed [SW-1:0] dc_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_k        <= GAIN_K_RESET;
      sample_period <= PERIOD_RESET;
      dc_offset     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GAIN_K:        gain_k        <= cfg_wdata[15:0];
        REG_SAMPLE_PERIOD: sample_period <= cfg_wdata[31:0];
        REG_DC_OFFSET:     dc_offset     <= cfg_wdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // scaled input with offset removed
  logic signed [SW:0]    diff;
  logic signed [UW-1:0]  u_full;
  logic signed [EW-1:0]  u_ext;
  logic                  u_over;
  logic signed [STW-1:0] u_val;

  assign diff   = (SW+1)'(in_sample) - (SW+1)'(dc_offset);
  assign u_full = {diff, {STATE_FRAC{1'b0}}};
  assign u_ext  = EW'(u_full);

  always_comb begin
    u_over = 1'b0;
    u_val  = STW'(u_ext);
    if (u_ext > EW'(ST_MAX)) begin
      u_over = 1'b1;
      u_val  = ST_MAX;
    end else if (u_ext < EW'(ST_MIN)) begin
      u_over = 1'b1;
      u_val  = ST_MIN;
    end
  end

  // working registers
  logic [OMEGA_W-1:0]    omega_r;
  logic signed [STW-1:0] u_r;
  logic [X_W-1:0]        x;
  logic [KX_W-1:0]       kx;
  logic [X2_W-1:0]       x2;
  logic [KX2_W-1:0]      kx2;
  logic [D_W-1:0]        dval;
  logic [Q_W-1:0]        ab0, aa1, aa2, bb0;
  logic                  aa1_neg, aa2_neg;
  logic [PREG_W-1:0]     preg;
  logic [PW-1:0]         prod;
  logic signed [STW-1:0] m;
  logic signed [STW-1:0] acc, tmp;
  logic signed [STW-1:0] bp1, bp2, lp1, lp2;
  logic                  sat_hit;

  // operand and coefficient selection
  logic signed [STW-1:0] s_op;
  logic [STW-1:0]        a_mag;
  logic [PREG_W-1:0]     a_ext;
  logic [MW-1:0]         cb;
  logic                  c_neg;
  logic                  neg;

  always_comb begin
    case (cmd.asel)
      A_BP1:   s_op = bp1;
      A_BP2:   s_op = bp2;
      A_LP1:   s_op = lp1;
      A_LP2:   s_op = lp2;
      A_TMP:   s_op = tmp;
      default: s_op = '0;
    endcase
    case (cmd.csel)
      C_NAA1:  begin cb = MW'(aa1); c_neg = ~aa1_neg; end
      C_NAA2:  begin cb = MW'(aa2); c_neg = ~aa2_neg; end
      C_AB0:   begin cb = MW'(ab0); c_neg = 1'b0; end
      C_NAB0:  begin cb = MW'(ab0); c_neg = 1'b1; end
      C_BB0:   begin cb = MW'(bb0); c_neg = 1'b0; end
      C_BB1:   begin cb = {bb0, 1'b0}; c_neg = 1'b0; end
      default: begin cb = '0; c_neg = 1'b0; end
    endcase
  end

  assign a_mag = s_op[STW-1] ? STW'(-s_op) : STW'(s_op);
  assign a_ext = PREG_W'(a_mag);
  assign neg   = s_op[STW-1] ^ c_neg;

  // shared multiplier
  logic [MW-1:0] ma, mb;

  always_comb begin
    case (cmd.mul)
      MS_OM_TS: begin ma = MW'(omega_r); mb = sample_period; end
      MS_K_X:   begin ma = MW'(gain_k);  mb = MW'(x); end
      MS_X_X:   begin ma = MW'(x);       mb = MW'(x); end
      MS_K_X2:  begin ma = MW'(gain_k);  mb = MW'(x2); end
      MS_LO:    begin ma = a_ext[MW-1:0]; mb = cb; end
      MS_HI:    begin ma = a_ext[PREG_W-1:MW]; mb = cb; end
      default:  begin ma = '0; mb = '0; end
    endcase
  end

  // coefficient numerators and divider
  logic [39:0]          wts;
  logic [D_W-1:0]       dsum;
  logic signed [NUM_W+1:0] num_s;
  logic                 num_neg;
  logic [NUM_W+1:0]     num_abs;
  logic [DVD_W-1:0]     dividend;
  logic [Q_W-1:0]       quotient;

  assign wts  = preg[55:16];
  assign dsum = FOUR_Q24 + D_W'({kx, 1'b0}) + D_W'(x2);

  always_comb begin
    case (cmd.num)
      N_AB0:   num_s = (NUM_W+2)'({kx, 1'b0});
      N_AA1:   num_s = (NUM_W+2)'({x2, 1'b0}) - (NUM_W+2)'({FOUR_Q24, 1'b0});
      N_AA2:   num_s = (NUM_W+2)'(FOUR_Q24) - (NUM_W+2)'({kx, 1'b0}) + (NUM_W+2)'(x2);
      N_BB0:   num_s = (NUM_W+2)'(kx2);
      default: num_s = '0;
    endcase
  end

  assign num_neg  = num_s[NUM_W+1];
  assign num_abs  = num_neg ? (NUM_W+2)'(-num_s) : (NUM_W+2)'(num_s);
  assign dividend = {num_abs[NUM_W-1:0], {COEF_FRAC{1'b0}}} + DVD_W'(dval >> 1);

  sogi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (dval),
    .busy     (sts.div_busy),
    .done     (sts.div_done),
    .quotient (quotient)
  );

  // product rounding and saturation
  logic [PW:0]           r_full;
  logic [RW-1:0]         r, lim, rc;
  logic                  r_over;
  logic [STW-1:0]        rc_st;

  assign r_full = {1'b0, prod} + RND_HALF;
  assign r      = r_full[PW:COEF_FRAC];
  assign lim    = RW'({1'b0, {(STW-1){1'b1}}}) + RW'(neg);
  assign r_over = r > lim;
  assign rc     = r_over ? lim : r;
  assign rc_st  = rc[STW-1:0];

  // saturating accumulate
  logic signed [STW:0]   sum;
  logic                  sum_over;
  logic signed [STW-1:0] sum_val;

  assign sum      = (STW+1)'(acc) + (STW+1)'(m);
  assign sum_over = sum[STW] != sum[STW-1];
  assign sum_val  = sum_over ? (sum[STW] ? ST_MIN : ST_MAX) : sum[STW-1:0];

  // output rounding
  logic signed [STW:0]   o_full;
  logic signed [OW-1:0]  oq;
  logic signed [CW-1:0]  oq_ext;
  logic                  o_over;
  logic signed [SW-1:0]  o_val;

  assign o_full = (STW+1)'(acc) + OUT_HALF;
  assign oq     = o_full[STW:STATE_FRAC];
  assign oq_ext = CW'(oq);

  always_comb begin
    o_over = 1'b0;
    o_val  = SW'(oq_ext);
    if (oq_ext > CW'(SMP_MAX)) begin
      o_over = 1'b1;
      o_val  = SMP_MAX;
    end else if (oq_ext < CW'(SMP_MIN)) begin
      o_over = 1'b1;
      o_val  = SMP_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bp1     <= '0;
      bp2     <= '0;
      lp1     <= '0;
      lp2     <= '0;
      sat_hit <= 1'b0;
    end else begin
      if (cmd.load) begin
        sat_hit <= u_over;
        if (in_restart) begin
          bp1 <= '0;
          bp2 <= '0;
          lp1 <= '0;
          lp2 <= '0;
        end
      end else if ((cmd.rnd && r_over) || (cmd.acc_add && sum_over) ||
                   ((cmd.outa_en || cmd.outb_en) && o_over)) begin
        sat_hit <= 1'b1;
      end
      if (cmd.shift_bp) begin
        bp2 <= bp1;
        bp1 <= tmp;
      end
      if (cmd.shift_lp) begin
        lp2 <= lp1;
        lp1 <= tmp;
      end
    end
  end

  always_ff @(posedge clk) begin
    preg <= ma * mb;
    if (cmd.load) begin
      omega_r <= in_omega;
      u_r     <= u_val;
    end
    if (cmd.x_en) x <= (wts > 40'(WTS_MAX)) ? WTS_MAX : wts[X_W-1:0];
    if (cmd.kx_en) kx <= preg[KX_W+11:12];
    if (cmd.x2_en) x2 <= preg[X2_W+23:24];
    if (cmd.kx2_en) begin
      kx2  <= preg[KX2_W+11:12];
      dval <= dsum;
    end
    if (cmd.coef_en) begin
      case (cmd.num)
        N_AB0:   ab0 <= quotient;
        N_AA1:   begin aa1 <= quotient; aa1_neg <= num_neg; end
        N_AA2:   begin aa2 <= quotient; aa2_neg <= num_neg; end
        N_BB0:   bb0 <= quotient;
        default: ;
      endcase
    end
    if (cmd.prod_lo) prod <= PW'(preg);
    if (cmd.prod_add) prod <= prod + (PW'(preg) << MW);
    if (cmd.rnd) m <= neg ? STW'(-rc_st) : STW'(rc_st);
    if (cmd.acc_u) acc <= u_r;
    else if (cmd.acc_clr) acc <= '0;
    else if (cmd.acc_add) acc <= sum_val;
    if (cmd.tmp_en) tmp <= acc;
    if (cmd.outa_en) alpha <= o_val;
    if (cmd.outb_en) beta <= o_val;
  end

  assign saturated = sat_hit;

endmodule

### sv/sogi_ctrl.sv
// controller: sequences coefficient setup, four divisions and nine state products
// uses sogi_pkg command and status records
module sogi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_free,
  input  sogi_pkg::dp_sts_t sts,
  output sogi_pkg::dp_cmd_t cmd
);
  import sogi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_WTS, S_X, S_KXM, S_KX, S_X2, S_KX2M, S_KX2,
    S_DGO, S_DWAIT, S_TLO, S_THI, S_TADD, S_TRND, S_TACC, S_POST, S_DONE
  } state_t;

  typedef struct packed {
    a_sel_t a;
    c_sel_t c;
  } term_t;

  localparam logic [3:0] T_INA = 4'd1;
  localparam logic [3:0] T_VA  = 4'd3;
  localparam logic [3:0] T_INB = 4'd5;
  localparam logic [3:0] T_VB  = 4'd8;

  function automatic term_t term_of(input logic [3:0] idx);
    term_t t;
    unique case (idx)
      4'd0:    t = '{A_BP1, C_NAA1};
      4'd1:    t = '{A_BP2, C_NAA2};
      4'd2:    t = '{A_TMP, C_AB0};
      4'd3:    t = '{A_BP2, C_NAB0};
      4'd4:    t = '{A_LP1, C_NAA1};
      4'd5:    t = '{A_LP2, C_NAA2};
      4'd6:    t = '{A_TMP, C_BB0};
      4'd7:    t = '{A_LP1, C_BB1};
      4'd8:    t = '{A_LP2, C_BB0};
      default: t = '{A_TMP, C_AB0};
    endcase
    return t;
  endfunction

  state_t     state;
  num_sel_t   ncur;
  logic [3:0] tidx;
  term_t      term;

  assign term     = term_of(tidx);
  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd      = '0;
    cmd.mul  = MS_LO;
    cmd.num  = ncur;
    cmd.asel = term.a;
    cmd.csel = term.c;
    unique case (state)
      S_IDLE:  cmd.load = in_valid;
      S_WTS:   begin cmd.mul = MS_OM_TS; cmd.acc_u = 1'b1; end
      S_X:     cmd.x_en = 1'b1;
      S_KXM:   cmd.mul = MS_K_X;
      S_KX:    begin cmd.kx_en = 1'b1; cmd.mul = MS_X_X; end
      S_X2:    cmd.x2_en = 1'b1;
      S_KX2M:  cmd.mul = MS_K_X2;
      S_KX2:   cmd.kx2_en = 1'b1;
      S_DGO:   cmd.div_start = 1'b1;
      S_DWAIT: cmd.coef_en = sts.div_done;
      S_TLO:   cmd.mul = MS_LO;
      S_THI:   begin cmd.mul = MS_HI; cmd.prod_lo = 1'b1; end
      S_TADD:  cmd.prod_add = 1'b1;
      S_TRND:  cmd.rnd = 1'b1;
      S_TACC:  cmd.acc_add = 1'b1;
      S_POST: begin
        unique case (tidx) inside
          T_INA, T_INB: begin cmd.tmp_en = 1'b1; cmd.acc_clr = 1'b1; end
          T_VA:  begin cmd.outa_en = 1'b1; cmd.shift_bp = 1'b1; cmd.acc_u = 1'b1; end
          T_VB:  begin cmd.outb_en = 1'b1; cmd.shift_lp = 1'b1; end
          default: ;
        endcase
      end
      S_DONE:  cmd.res_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ncur  <= N_AB0;
      tidx  <= '0;
    end else begin
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_WTS;
        S_WTS:   state <= S_X;
        S_X:     state <= S_KXM;
        S_KXM:   state <= S_KX;
        S_KX:    state <= S_X2;
        S_X2:    state <= S_KX2M;
        S_KX2M:  state <= S_KX2;
        S_KX2: begin
          ncur  <= N_AB0;
          state <= S_DGO;
        end
        S_DGO:   state <= S_DWAIT;
        S_DWAIT: begin
          if (sts.div_done) begin
            if (ncur == N_BB0) begin
              tidx  <= '0;
              state <= S_TLO;
            end else begin
              ncur  <= num_sel_t'(2'(ncur + 2'd1));
              state <= S_DGO;
            end
          end
        end
        S_TLO:   state <= S_THI;
        S_THI:   state <= S_TADD;
        S_TADD:  state <= S_TRND;
        S_TRND:  state <= S_TACC;
        S_TACC: begin
          if (tidx == T_INA || tidx == T_VA || tidx == T_INB || tidx == T_VB) begin
            state <= S_POST;
          end else begin
            tidx  <= tidx + 4'd1;
            state <= S_TLO;
          end
        end
        S_POST: begin
          if (tidx == T_VB) begin
            state <= S_DONE;
          end else begin
            tidx  <= tidx + 4'd1;
            state <= S_TLO;
          end
        end
        S_DONE:  if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_coef_on_done: assert property (@(posedge clk) disable iff (rst)
    cmd.coef_en |-> sts.div_done)
    else $error("coefficient stored without divider result");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  a_res_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> out_free)
    else $error("result written over a waiting beat");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_WTS)
    else $error("accepted beat did not start the sequence");

endmodule

### sv/sogi_quadrature_generator.sv
// top level of the sogi quadrature generator: stream ports and output register
// uses sogi_pkg, sogi_ctrl and sogi_dp
//
//  channel  | signals                      | payload
//  s_axis   | tvalid tready tdata tuser    | sample, omega / restart
//  m_axis   | tvalid tready tdata tuser    | alpha, beta / saturated
//  cfg      | cfg_wr_en cfg_index cfg_wdata| gain_k, sample_period, dc_offset
//
// per beat the controller runs the coefficient products, four divisions on the radix-2
// divider, nine state products on the shared 32x32 multiplier and a hand-off
// the next input beat is taken while a finished result waits in the output register
// synchronous reset clears the filter states; no clearing pass
module sogi_quadrature_generator #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int STATE_WIDTH  = 48
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // sample, omega
  input  logic [((SAMPLE_WIDTH+sogi_pkg::OMEGA_W+7)/8)*8-1:0] s_axis_tdata,
  // restart
  input  logic                                       s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // alpha, beta
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
  // saturated
  output logic                                       m_axis_tuser,
  input  logic                                       cfg_wr_en,
  input  logic [sogi_pkg::CFG_IW-1:0]                cfg_index,
  input  logic [sogi_pkg::CFG_DW-1:0]                cfg_wdata
);
  import sogi_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int OUT_W = ((2*SW+7)/8)*8;

  dp_cmd_t              cmd;
  dp_sts_t              sts;
  logic                 out_free;
  logic signed [SW-1:0] alpha, beta;
  logic                 saturated;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  sogi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  sogi_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_sample  (s_axis_tdata[SW-1:0]),
    .in_omega   (s_axis_tdata[SW+OMEGA_W-1:SW]),
    .in_restart (s_axis_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .alpha      (alpha),
    .beta       (beta),
    .saturated  (saturated)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      m_axis_tdata <= OUT_W'({beta, alpha});
      m_axis_tuser <= saturated;
    end
  end

endmodule

### sim/sogi_checker.sv
// result checker for the sogi quadrature generator: watches the input, output and
// register write channels, predicts alpha, beta and the clip flag per input beat
// depends on sogi_pkg
`timescale 1ns / 1ps

module sogi_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // sample, omega
  input  logic [39:0] s_axis_tdata,
  // restart
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // alpha, beta
  input  logic [31:0] m_axis_tdata,
  // saturated
  input  logic        m_axis_tuser,
  input  logic        cfg_wr_en,
  input  logic [sogi_pkg::CFG_IW-1:0] cfg_index,
  input  logic [sogi_pkg::CFG_DW-1:0] cfg_wdata,
  output int          mismatches,
  output int          outstanding
);
  import sogi_pkg::*;

  localparam longint ST_MAX  = (64'sd1 <<< 47) - 1;
  localparam longint ST_MIN  = -ST_MAX - 1;
  localparam longint ONE_Q24 = 64'sd1 <<< 24;

  typedef struct packed {
    logic [15:0] alpha;
    logic [15:0] beta;
    logic        saturated;
  } sogi_out_t;

  sogi_out_t   expected_q[$];
  logic [15:0] k_reg;
  logic [31:0] ts_reg;
  logic [15:0] offset_reg;
  longint      bp1, bp2, lp1, lp2;
  logic        clipped;

  function automatic longint clip_state(longint v);
    if (v > ST_MAX) begin
      clipped = 1'b1;
      return ST_MAX;
    end
    if (v < ST_MIN) begin
      clipped = 1'b1;
      return ST_MIN;
    end
    return v;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // state times q.28 coefficient, magnitude rounded half away from zero
  function automatic longint scale_q28(longint s, longint c);
    logic         neg;
    logic [127:0] p;
    logic [127:0] lim;
    neg = (s < 0) != (c < 0);
    p = {64'd0, mag(s)} * {64'd0, mag(c)};
    p = (p + (128'd1 << 27)) >> 28;
    lim = 128'(ST_MAX) + (neg ? 128'd1 : 128'd0);
    if (p > lim) begin
      clipped = 1'b1;
      p = lim;
    end
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint coef_q28(longint n, longint d);
    logic [63:0] q;
    q = ((64'(mag(n)) << 28) + (64'(d) >> 1)) / 64'(d);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] round_out(longint v);
    longint q;
    q = v >>> 16;
    if (v[15]) q = q + 1;
    if (q > 32767) begin
      clipped = 1'b1;
      q = 32767;
    end
    if (q < -32768) begin
      clipped = 1'b1;
      q = -32768;
    end
    return q[15:0];
  endfunction

  task automatic predict_beat(logic [15:0] smp, logic [23:0] om, logic restart);
    logic [63:0] x, kx, x2, kx2;
    longint      d, ab0, aa1, aa2, bb0, u, ina, inb, va, vb;
    sogi_out_t   r;
    clipped = 1'b0;
    if (restart) begin
      bp1 = 0; bp2 = 0; lp1 = 0; lp2 = 0;
    end
    x = (64'(om) * 64'(ts_reg)) >> 16;
    if (x > 64'(WTS_MAX)) x = 64'(WTS_MAX);
    kx  = (64'(k_reg) * x) >> 12;
    x2  = (x * x) >> 24;
    kx2 = (64'(k_reg) * x2) >> 12;
    d   = 4 * ONE_Q24 + 2 * longint'(kx) + longint'(x2);
    ab0 = coef_q28(2 * longint'(kx), d);
    aa1 = coef_q28(2 * (longint'(x2) - 4 * ONE_Q24), d);
    aa2 = coef_q28(4 * ONE_Q24 - 2 * longint'(kx) + longint'(x2), d);
    bb0 = coef_q28(longint'(kx2), d);
    u = clip_state((longint'($signed(smp)) - longint'($signed(offset_reg))) * 65536);

    ina = clip_state(clip_state(u + scale_q28(bp1, -aa1)) + scale_q28(bp2, -aa2));
    va  = clip_state(scale_q28(ina, ab0) + scale_q28(bp2, -ab0));
    bp2 = bp1;
    bp1 = ina;

    inb = clip_state(clip_state(u + scale_q28(lp1, -aa1)) + scale_q28(lp2, -aa2));
    vb  = clip_state(clip_state(scale_q28(inb, bb0) + scale_q28(lp1, 2 * bb0))
                     + scale_q28(lp2, bb0));
    lp2 = lp1;
    lp1 = inb;

    r.alpha = round_out(va);
    r.beta  = round_out(vb);
    r.saturated = clipped;
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    sogi_out_t want;
    if (rst) begin
      k_reg <= GAIN_K_RESET;
      ts_reg <= PERIOD_RESET;
      offset_reg <= 16'd0;
      bp1 = 0; bp2 = 0; lp1 = 0; lp2 = 0;
      expected_q.delete();
      mismatches <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_GAIN_K: begin
            k_reg <= cfg_wdata[15:0];
          end
          REG_SAMPLE_PERIOD: begin
            ts_reg <= cfg_wdata;
          end
          REG_DC_OFFSET: begin
            offset_reg <= cfg_wdata[15:0];
          end
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_beat(s_axis_tdata[15:0], s_axis_tdata[39:16], s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result beat %h/%b", m_axis_tdata,
                                        m_axis_tuser);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.alpha !== m_axis_tdata[15:0] || want.beta !== m_axis_tdata[31:16] ||
              want.saturated !== m_axis_tuser) begin
            if (mismatches < 10)
              $display("mismatch: alpha %h/%h beta %h/%h sat %b/%b (exp/got)",
                       want.alpha, m_axis_tdata[15:0], want.beta, m_axis_tdata[31:16],
                       want.saturated, m_axis_tuser);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

### sim/tb_sogi_quadrature_generator.sv
// testbench top for the sogi quadrature generator: clock, reset, register phases,
// directed and random input beats, random output stalls and the verdict
// depends on sogi_pkg, sogi_quadrature_generator and sogi_checker
`timescale 1ns / 1ps

module tb_sogi_quadrature_generator;
  import sogi_pkg::*;

  localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 400;
  localparam logic [23:0] OMEGA_50HZ = 24'd80425;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  int          mismatches;
  int          outstanding;
  int          idle_cycles = 0;
  int          stall_left = 0;
  logic        steady_sink = 1'b0;
  logic        steady_source = 1'b0;

  always #2 clk = ~clk;

  sogi_quadrature_generator uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  sogi_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 400);
  endfunction

  // output side stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (steady_sink) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_beat(logic [15:0] smp, logic [23:0] om, logic restart);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {om, smp};
    s_axis_tuser <= restart;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    gap = steady_source ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_beats(int count);
    logic [23:0] om;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 9);
      if (r < 6) om = OMEGA_50HZ + 24'($urandom_range(0, 8000)) - 24'd4000;
      else if (r < 8) om = 24'($urandom_range(0, 400000));
      else om = 24'($urandom);
      send_beat(16'($urandom), om, $urandom_range(0, 39) == 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes of sample and omega, restart, clipped wts
    send_beat(16'h7FFF, OMEGA_50HZ, 1'b1);
    send_beat(16'h7FFF, OMEGA_50HZ, 1'b0);
    send_beat(16'h8000, OMEGA_50HZ, 1'b0);
    send_beat(16'h0000, 24'd0, 1'b0);
    send_beat(16'h8000, 24'd0, 1'b0);
    send_beat(16'h7FFF, 24'hFFFFFF, 1'b0);
    send_beat(16'h8000, 24'hFFFFFF, 1'b0);
    send_beat(16'h1234, 24'h800000, 1'b1);
    send_beat(16'hFFFF, 24'h000001, 1'b0);
    drain();

    // high gain, shortest period, lowest offset; unused index ignored
    write_reg(REG_GAIN_K, 32'hFFFF);
    write_reg(REG_SAMPLE_PERIOD, 32'd1);
    write_reg(REG_DC_OFFSET, 32'h8000);
    write_reg(REG_UNUSED, 32'hFFFFFFFF);
    send_beat(16'h7FFF, 24'hFFFFFF, 1'b1);
    send_beat(16'h8000, 24'hFFFFFF, 1'b0);
    send_beat(16'h7FFF, 24'd0, 1'b0);
    random_beats(220);
    drain();

    // longest period, zero gain, highest offset
    write_reg(REG_GAIN_K, 32'd0);
    write_reg(REG_SAMPLE_PERIOD, 32'hFFFFFFFF);
    write_reg(REG_DC_OFFSET, 32'h7FFF);
    send_beat(16'h8000, OMEGA_50HZ, 1'b1);
    send_beat(16'h8000, 24'hFFFFFF, 1'b0);
    random_beats(220);
    drain();

    // max gain with long period: heavy clipping
    write_reg(REG_GAIN_K, 32'hFFFF);
    random_beats(200);
    drain();

    // back to defaults, no idling on either side
    steady_sink = 1'b1;
    steady_source = 1'b1;
    write_reg(REG_GAIN_K, 32'(GAIN_K_RESET));
    write_reg(REG_SAMPLE_PERIOD, 32'(PERIOD_RESET));
    write_reg(REG_DC_OFFSET, 32'd0);
    random_beats(200);
    drain();
    steady_sink = 1'b0;
    steady_source = 1'b0;

    for (int p = 0; p < 3; p++) begin
      write_reg(REG_GAIN_K, 32'($urandom_range(0, 65535)));
      write_reg(REG_SAMPLE_PERIOD, $urandom_range(1, 2000000));
      write_reg(REG_DC_OFFSET, 32'($urandom_range(0, 65535)));
      random_beats(170);
      drain();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
